// ===== hw/rtl/owrg_pkg.sv =====
package owrg_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_WLOCAL = 2'd1,
        OP_ZERO   = 2'd2,
        OP_DONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        A_ISSUE    = 4'd0,
        A_REJECT   = 4'd1,
        A_PARK_COV = 4'd2,
        A_PARK_DLY = 4'd3,
        A_FINISH   = 4'd4,
        A_REISSUE  = 4'd5,
        A_TBL_FULL = 4'd6,
        A_WTR_FULL = 4'd7,
        A_RELEASE  = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PARK,
        S_EMIT,
        S_DRN_RD,
        S_DRN_EV,
        S_REL
    } t_state;

    // one parked request
    typedef struct packed {
        logic [15:0] tag;
        logic [1:0]  kind;
        logic        cov;
        logic [63:0] start;
        logic [31:0] count;
    } t_waiter;

    // slot table update strobes
    typedef struct packed {
        logic alloc;
        logic drop;
        logic bump;
    } t_slot_cmd;

    localparam logic [2:0] NPASS = 3'd6;

endpackage

// ===== hw/rtl/overlapping_write_range_guard_top.sv =====
// Write range guard: tracks in-flight block ranges and parks overlapping requests.
// Input channel (i_in_valid / o_in_stall): operation 0..2 is a new request, 3 is
// a completion of an in-flight slot. A transfer happens when valid is high and
// stall is low; one item is handled at a time, stall stays high until its
// last result is loaded into the output register.
// Output channel (o_out_valid / i_out_stall): one result per transfer, o_last
// marks the final result of an input item. The output register frees the
// engine while a result waits for the receiver.
// Sequence: a new request gives one result via S_LOOK then S_EMIT (a rejected
// write goes straight to S_EMIT; one that lands on a busy slot adds S_PARK). A
// completion scans the slot's waiter memory in six passes (covered then delayed,
// each by kind), each pass reading the filled waiters one at a time through the
// single read port of the waiter memory, then emits the release. The next input
// transfer can come in the same cycle as the last result transfer; a stale
// completion gives no result. When the receiver stalls, the engine holds at the
// next result until the output register drains.
// Reset (synchronous, i_rst_n low) clears all slots, fill counts and the
// mounted flag. Waiter memory is not cleared; only filled entries are read.
// APB: register 0 (volume_mounted) at address 0, always ready.
module overlapping_write_range_guard_top import owrg_pkg::*; #(
    parameter int SLOTS = 16,
    parameter int WPS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_request_tag,
    input  logic [63:0] i_start_block,
    input  logic [31:0] i_block_count,
    input  logic [3:0]  i_done_slot,
    input  logic [31:0] i_done_status,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_action,
    output logic [15:0] o_out_tag,
    output logic [1:0]  o_out_kind,
    output logic [63:0] o_out_start,
    output logic [31:0] o_out_count,
    output logic [3:0]  o_out_slot,
    output logic [31:0] o_out_status,
    output logic        o_last
);

    localparam int SW = $clog2(SLOTS);
    localparam int FW = $clog2(WPS + 1);
    localparam int IW = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int AW = SW + IW;

    // configuration
    logic r_mounted;
    assign pready = 1'b1;
    assign prdata = {31'd0, r_mounted};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mounted <= 1'b0;
        end else if (psel && penable && pwrite && !paddr) begin
            r_mounted <= pwdata[0];
        end
    end

    // request latch
    t_state        r_state, n_state;
    t_op           r_op;
    logic [15:0]   r_tag;
    logic [63:0]   r_start, r_end;
    logic [31:0]   r_count, r_status;
    logic [SW-1:0] r_slot, n_slot;
    t_action       r_res_act, n_res_act;
    logic [SW-1:0] r_res_slot, n_res_slot;
    logic          r_cov, n_cov;
    logic [2:0]    r_pass, n_pass;
    logic [FW-1:0] r_idx, n_idx;

    // output register
    logic          r_ov;
    t_action       r_o_act;
    logic [15:0]   r_o_tag;
    logic [1:0]    r_o_kind;
    logic [63:0]   r_o_start;
    logic [31:0]   r_o_count, r_o_status;
    logic [3:0]    r_o_slot;
    logic          r_o_last;

    // saturating range end of the incoming request
    logic [31:0] w_span;
    logic [64:0] w_sum;
    logic [63:0] w_end;
    assign w_span = (i_block_count != 32'd0) ? i_block_count - 32'd1 : 32'd0;
    assign w_sum  = {1'b0, i_start_block} + {33'd0, w_span};
    assign w_end  = w_sum[64] ? '1 : w_sum[63:0];

    logic          w_hit_any, w_hit_cov, w_free_any, w_sel_valid;
    logic [SW-1:0] w_hit_idx, w_free_idx;
    logic [FW-1:0] w_sel_fill;
    logic [63:0]   w_sel_start;
    logic [31:0]   w_sel_count;
    t_slot_cmd     w_cmd;

    owrg_slots #(.SLOTS(SLOTS), .WPS(WPS), .SW(SW), .FW(FW)) u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_start   (r_start),
        .i_q_end     (r_end),
        .i_q_count   (r_count),
        .i_sel       (r_slot),
        .i_cmd       (w_cmd),
        .o_hit_any   (w_hit_any),
        .o_hit_idx   (w_hit_idx),
        .o_hit_cov   (w_hit_cov),
        .o_free_any  (w_free_any),
        .o_free_idx  (w_free_idx),
        .o_sel_valid (w_sel_valid),
        .o_sel_fill  (w_sel_fill),
        .o_sel_start (w_sel_start),
        .o_sel_count (w_sel_count)
    );

    logic    w_we;
    t_waiter w_wdata, w_rdata;

    assign w_wdata = '{tag: r_tag, kind: r_op, cov: r_cov, start: r_start, count: r_count};

    owrg_wmem #(.AW(AW)) u_wmem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({r_slot, IW'(w_sel_fill)}),
        .i_wdata (w_wdata),
        .i_raddr ({r_slot, IW'(r_idx)}),
        .o_rdata (w_rdata)
    );

    // drain pass decode: covered waiters first, each pass one kind
    logic       w_want_cov;
    logic [1:0] w_kind;
    logic       w_match;
    assign w_want_cov = (r_pass < 3'd3);
    assign w_kind     = w_want_cov ? r_pass[1:0] : 2'(r_pass - 3'd3);
    assign w_match    = (w_rdata.cov == w_want_cov) && (w_rdata.kind == w_kind);

    logic w_can_emit;
    assign w_can_emit = !r_ov || !i_out_stall;

    logic          e_valid, e_last;
    t_action       e_act;
    logic [15:0]   e_tag;
    logic [1:0]    e_kind;
    logic [63:0]   e_start;
    logic [31:0]   e_count, e_status;
    logic [SW-1:0] e_slot;

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_res_act  = r_res_act;
        n_res_slot = r_res_slot;
        n_cov      = r_cov;
        n_pass     = r_pass;
        n_idx      = r_idx;
        w_cmd      = '0;
        w_we       = 1'b0;
        e_valid    = 1'b0;
        e_last     = 1'b1;
        e_act      = r_res_act;
        e_tag      = r_tag;
        e_kind     = r_op;
        e_start    = r_start;
        e_count    = r_count;
        e_status   = 32'd0;
        e_slot     = r_res_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pass = '0;
                    n_idx  = '0;
                    if (t_op'(i_operation) == OP_DONE) begin
                        n_slot = SW'(i_done_slot);
                        if (32'(i_done_slot) < SLOTS) begin
                            n_state = S_DRN_RD;
                        end
                    end else if (t_op'(i_operation) == OP_WRITE && !r_mounted) begin
                        n_res_act  = A_REJECT;
                        n_res_slot = '0;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (w_hit_any) begin
                    n_slot  = w_hit_idx;
                    n_cov   = w_hit_cov;
                    n_state = S_PARK;
                end else if (w_free_any) begin
                    w_cmd.alloc = 1'b1;
                    n_res_act   = A_ISSUE;
                    n_res_slot  = w_free_idx;
                    n_state     = S_EMIT;
                end else begin
                    n_res_act  = A_TBL_FULL;
                    n_res_slot = '0;
                    n_state    = S_EMIT;
                end
            end
            S_PARK: begin
                n_res_slot = r_slot;
                if (32'(w_sel_fill) >= WPS) begin
                    n_res_act = A_WTR_FULL;
                end else begin
                    w_we       = 1'b1;
                    w_cmd.bump = 1'b1;
                    n_res_act  = r_cov ? A_PARK_COV : A_PARK_DLY;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                e_valid = 1'b1;
                if (w_can_emit) begin
                    n_state = S_IDLE;
                end
            end
            S_DRN_RD: begin
                // stale completion: slot not in flight
                if (!w_sel_valid) begin
                    n_state = S_IDLE;
                end else if (r_idx >= w_sel_fill) begin
                    n_idx = '0;
                    if (r_pass == NPASS - 3'd1) begin
                        n_state = S_REL;
                    end else begin
                        n_pass = r_pass + 3'd1;
                    end
                end else begin
                    n_state = S_DRN_EV;
                end
            end
            S_DRN_EV: begin
                e_valid  = w_match;
                e_last   = 1'b0;
                e_act    = w_want_cov ? A_FINISH : A_REISSUE;
                e_tag    = w_rdata.tag;
                e_kind   = w_rdata.kind;
                e_start  = w_rdata.start;
                e_count  = w_rdata.count;
                e_status = w_want_cov ? r_status : 32'd0;
                e_slot   = r_slot;
                if (!w_match || w_can_emit) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DRN_RD;
                end
            end
            S_REL: begin
                e_valid  = 1'b1;
                e_act    = A_RELEASE;
                e_tag    = '0;
                e_kind   = '0;
                e_start  = w_sel_start;
                e_count  = w_sel_count;
                e_status = r_status;
                e_slot   = r_slot;
                if (w_can_emit) begin
                    w_cmd.drop = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (e_valid && w_can_emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_res_act  <= n_res_act;
        r_res_slot <= n_res_slot;
        r_cov      <= n_cov;
        r_pass     <= n_pass;
        r_idx      <= n_idx;
        if (r_state == S_IDLE && i_in_valid) begin
            r_op     <= t_op'(i_operation);
            r_tag    <= i_request_tag;
            r_start  <= i_start_block;
            r_count  <= i_block_count;
            r_end    <= w_end;
            r_status <= i_done_status;
        end
        if (e_valid && w_can_emit) begin
            r_o_act    <= e_act;
            r_o_tag    <= e_tag;
            r_o_kind   <= e_kind;
            r_o_start  <= e_start;
            r_o_count  <= e_count;
            r_o_slot   <= 4'(e_slot);
            r_o_status <= e_status;
            r_o_last   <= e_last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_action     = r_o_act;
    assign o_out_tag    = r_o_tag;
    assign o_out_kind   = r_o_kind;
    assign o_out_start  = r_o_start;
    assign o_out_count  = r_o_count;
    assign o_out_slot   = r_o_slot;
    assign o_out_status = r_o_status;
    assign o_last       = r_o_last;

`ifndef SYNTHESIS
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.alloc |-> w_free_any)
        else $error("slot allocated with no free slot");

    a_bump_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.bump |-> (32'(w_sel_fill) < WPS))
        else $error("waiter list overfilled");

    a_drain_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRN_EV) |-> (r_idx < w_sel_fill))
        else $error("drain read past fill");
`endif

endmodule

// ===== hw/rtl/owrg_slots.sv =====
module owrg_slots import owrg_pkg::*; #(
    parameter int SLOTS = 16,
    parameter int WPS   = 8,
    parameter int SW    = $clog2(SLOTS),
    parameter int FW    = $clog2(WPS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [63:0]   i_q_start,
    input  logic [63:0]   i_q_end,
    input  logic [31:0]   i_q_count,
    input  logic [SW-1:0] i_sel,
    input  t_slot_cmd     i_cmd,
    output logic          o_hit_any,
    output logic [SW-1:0] o_hit_idx,
    output logic          o_hit_cov,
    output logic          o_free_any,
    output logic [SW-1:0] o_free_idx,
    output logic          o_sel_valid,
    output logic [FW-1:0] o_sel_fill,
    output logic [63:0]   o_sel_start,
    output logic [31:0]   o_sel_count
);

    logic [SLOTS-1:0] r_valid;
    logic [FW-1:0]    r_fill  [SLOTS];
    logic [63:0]      r_start [SLOTS];
    logic [63:0]      r_end   [SLOTS];
    logic [31:0]      r_count [SLOTS];

    logic [SLOTS-1:0] w_ovl;
    logic [SLOTS-1:0] w_ctn;

    // parallel range compare against every slot
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            w_ovl[s] = r_valid[s] && (r_start[s] <= i_q_end) && (i_q_start <= r_end[s]);
            w_ctn[s] = (r_start[s] <= i_q_start) && (i_q_end <= r_end[s]);
        end
    end

    always_comb begin
        o_hit_any  = 1'b0;
        o_hit_idx  = '0;
        o_free_any = 1'b0;
        o_free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (w_ovl[s]) begin
                o_hit_any = 1'b1;
                o_hit_idx = SW'(s);
            end
            if (!r_valid[s]) begin
                o_free_any = 1'b1;
                o_free_idx = SW'(s);
            end
        end
    end

    assign o_hit_cov   = w_ctn[o_hit_idx];
    assign o_sel_valid = r_valid[i_sel];
    assign o_sel_fill  = r_fill[i_sel];
    assign o_sel_start = r_start[i_sel];
    assign o_sel_count = r_count[i_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            if (i_cmd.alloc) begin
                r_valid[o_free_idx] <= 1'b1;
                r_fill[o_free_idx]  <= '0;
            end
            if (i_cmd.drop) begin
                r_valid[i_sel] <= 1'b0;
                r_fill[i_sel]  <= '0;
            end
            if (i_cmd.bump) begin
                r_fill[i_sel] <= r_fill[i_sel] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_start[o_free_idx] <= i_q_start;
            r_end[o_free_idx]   <= i_q_end;
            r_count[o_free_idx] <= i_q_count;
        end
    end

endmodule

// ===== hw/rtl/owrg_wmem.sv =====
module owrg_wmem import owrg_pkg::*; #(
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_waiter       i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_waiter       o_rdata
);

    t_waiter r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
